/* src/sts_pkg.sv */
// Shared types, token kind codes and character-class helpers for the token scanner.
// Depends on nothing; used by sts_core, sts_out_fifo and script_token_scanner.
package sts_pkg;

	localparam int LINE_LENGTH_MAX_DEF = 4096;
	localparam int KEYWORD_CHARS_DEF = 8;
	localparam int KW_COUNT = 21;
	localparam int KW_MAX_LEN = 8;

	localparam logic [5:0] KIND_PLUS = 6'd0;
	localparam logic [5:0] KIND_INC = 6'd1;
	localparam logic [5:0] KIND_ADD_EQ = 6'd2;
	localparam logic [5:0] KIND_MINUS = 6'd3;
	localparam logic [5:0] KIND_DEC = 6'd4;
	localparam logic [5:0] KIND_SUB_EQ = 6'd5;
	localparam logic [5:0] KIND_SLASH = 6'd6;
	localparam logic [5:0] KIND_DSLASH = 6'd7;
	localparam logic [5:0] KIND_STAR = 6'd8;
	localparam logic [5:0] KIND_DSTAR = 6'd9;
	localparam logic [5:0] KIND_PERCENT = 6'd10;
	localparam logic [5:0] KIND_ASSIGN = 6'd11;
	localparam logic [5:0] KIND_EQ = 6'd12;
	localparam logic [5:0] KIND_NOT = 6'd13;
	localparam logic [5:0] KIND_NE = 6'd14;
	localparam logic [5:0] KIND_GT = 6'd15;
	localparam logic [5:0] KIND_GE = 6'd16;
	localparam logic [5:0] KIND_LT = 6'd17;
	localparam logic [5:0] KIND_LE = 6'd18;
	localparam logic [5:0] KIND_AMP = 6'd19;
	localparam logic [5:0] KIND_AND = 6'd20;
	localparam logic [5:0] KIND_BAR = 6'd21;
	localparam logic [5:0] KIND_OR = 6'd22;
	localparam logic [5:0] KIND_TILDE = 6'd23;
	localparam logic [5:0] KIND_CARET = 6'd24;
	localparam logic [5:0] KIND_COLON = 6'd25;
	localparam logic [5:0] KIND_SEMI = 6'd26;
	localparam logic [5:0] KIND_QUEST = 6'd27;
	localparam logic [5:0] KIND_DOT = 6'd28;
	localparam logic [5:0] KIND_COMMA = 6'd29;
	localparam logic [5:0] KIND_AT = 6'd30;
	localparam logic [5:0] KIND_LPAREN = 6'd31;
	localparam logic [5:0] KIND_RPAREN = 6'd32;
	localparam logic [5:0] KIND_LBRACK = 6'd33;
	localparam logic [5:0] KIND_RBRACK = 6'd34;
	localparam logic [5:0] KIND_LBRACE = 6'd35;
	localparam logic [5:0] KIND_RBRACE = 6'd36;
	localparam logic [5:0] KIND_IDENT = 6'd37;
	localparam logic [5:0] KIND_INT = 6'd38;
	localparam logic [5:0] KIND_REAL = 6'd39;
	localparam logic [5:0] KIND_STRING = 6'd40;
	localparam logic [5:0] KIND_KW_BASE = 6'd41;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_EQ = 8'h3D;

	// Keyword spellings, right-justified: last character in the low byte
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("fct"), 64'("false"), 64'("for"), 64'("ctor"), 64'("continue"),
		64'("vid"), 64'("virt"), 64'("pi"), 64'("pkg"), 64'("tau"),
		64'("true"), 64'("e"), 64'("else"), 64'("struct"), 64'("return"),
		64'("dtor"), 64'("main"), 64'("use"), 64'("let"), 64'("if"),
		64'("break")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd5, 4'd3, 4'd4, 4'd8, 4'd3, 4'd4, 4'd2, 4'd3, 4'd3,
		4'd4, 4'd1, 4'd4, 4'd6, 4'd6, 4'd4, 4'd4, 4'd3, 4'd3, 4'd2, 4'd5
	};

	typedef enum logic [5:0] {
		MODE_IDLE    = 6'b000001,
		MODE_OP      = 6'b000010,
		MODE_NUMBER  = 6'b000100,
		MODE_STRING  = 6'b001000,
		MODE_WORD    = 6'b010000,
		MODE_COMMENT = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] line;
		logic [11:0] start;
		logic [12:0] len;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       r0;
		tok_t       r1;
	} rlist_t;

	typedef struct packed {
		logic v;
		tok_t t;
	} flush_t;

	typedef logic [KW_MAX_LEN-1:0][7:0] kbuf_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A)) || (c == 8'h5F);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13) || (c == 8'd32);
	endfunction

	// Single-character tokens that never combine; bit 6 flags a hit
	function automatic logic [6:0] lone_kind(input logic [7:0] c);
		logic [6:0] k;
		k = 7'd0;
		case (c)
			8'h25: k = {1'b1, KIND_PERCENT};
			8'h7E: k = {1'b1, KIND_TILDE};
			8'h5E: k = {1'b1, KIND_CARET};
			8'h3A: k = {1'b1, KIND_COLON};
			8'h3B: k = {1'b1, KIND_SEMI};
			8'h3F: k = {1'b1, KIND_QUEST};
			8'h2C: k = {1'b1, KIND_COMMA};
			8'h40: k = {1'b1, KIND_AT};
			8'h28: k = {1'b1, KIND_LPAREN};
			8'h29: k = {1'b1, KIND_RPAREN};
			8'h5B: k = {1'b1, KIND_LBRACK};
			8'h5D: k = {1'b1, KIND_RBRACK};
			8'h7B: k = {1'b1, KIND_LBRACE};
			8'h7D: k = {1'b1, KIND_RBRACE};
			default: k = 7'd0;
		endcase
		return k;
	endfunction

	// Characters that may open a two-character operator
	function automatic logic [6:0] starter_kind(input logic [7:0] c);
		logic [6:0] k;
		k = 7'd0;
		case (c)
			8'h2B: k = {1'b1, KIND_PLUS};
			8'h2D: k = {1'b1, KIND_MINUS};
			8'h2F: k = {1'b1, KIND_SLASH};
			8'h2A: k = {1'b1, KIND_STAR};
			8'h3D: k = {1'b1, KIND_ASSIGN};
			8'h21: k = {1'b1, KIND_NOT};
			8'h3E: k = {1'b1, KIND_GT};
			8'h3C: k = {1'b1, KIND_LT};
			8'h26: k = {1'b1, KIND_AMP};
			8'h7C: k = {1'b1, KIND_BAR};
			8'h2E: k = {1'b1, KIND_DOT};
			default: k = 7'd0;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		logic [6:0] k;
		k = 7'd0;
		case (a)
			8'h2B: begin
				if (b == 8'h2B) k = {1'b1, KIND_INC};
				else if (b == CH_EQ) k = {1'b1, KIND_ADD_EQ};
			end
			8'h2D: begin
				if (b == 8'h2D) k = {1'b1, KIND_DEC};
				else if (b == CH_EQ) k = {1'b1, KIND_SUB_EQ};
			end
			8'h2F: if (b == 8'h2F) k = {1'b1, KIND_DSLASH};
			8'h2A: if (b == 8'h2A) k = {1'b1, KIND_DSTAR};
			8'h3D: if (b == CH_EQ) k = {1'b1, KIND_EQ};
			8'h21: if (b == CH_EQ) k = {1'b1, KIND_NE};
			8'h3E: if (b == CH_EQ) k = {1'b1, KIND_GE};
			8'h3C: if (b == CH_EQ) k = {1'b1, KIND_LE};
			8'h26: if (b == 8'h26) k = {1'b1, KIND_AND};
			8'h7C: if (b == 8'h7C) k = {1'b1, KIND_OR};
			default: k = 7'd0;
		endcase
		return k;
	endfunction

	function automatic logic [11:0] span(input logic [11:0] col, input logic [11:0] ts);
		return (col >= ts) ? col - ts : 12'd0;
	endfunction

	// Exact keyword match on length and characters
	function automatic logic [5:0] classify(input kbuf_t kb, input logic [11:0] len,
			input logic [12:0] kw_chars);
		logic [5:0] k;
		logic       hit;
		k = KIND_IDENT;
		for (int e = KW_COUNT - 1; e >= 0; e--) begin
			hit = ({8'd0, KW_LEN[e]} == len);
			for (int i = 0; i < KW_MAX_LEN; i++) begin
				if (i < int'(KW_LEN[e]) &&
					kb[i] != KW_TEXT[e][8*(int'(KW_LEN[e])-1-i) +: 8])
					hit = 1'b0;
			end
			if (hit) k = KIND_KW_BASE + 6'(e);
		end
		if (len == 12'd0 || {1'b0, len} > kw_chars) k = KIND_IDENT;
		return k;
	endfunction

	function automatic tok_t mk_tok(input logic [5:0] kind, input logic [15:0] line,
			input logic [11:0] start, input logic [11:0] len);
		tok_t t;
		t.kind = kind;
		t.line = line;
		t.start = start;
		t.len = {1'b0, len};
		t.last = 1'b0;
		return t;
	endfunction

	// Append a result; a third one is dropped
	function automatic rlist_t put(input rlist_t l, input tok_t t);
		rlist_t o;
		o = l;
		if (l.n == 2'd0) begin
			o.r0 = t;
			o.n = 2'd1;
		end else if (l.n == 2'd1) begin
			o.r1 = t;
			o.n = 2'd2;
		end
		return o;
	endfunction

	// Close whatever token is in progress
	function automatic flush_t flush_tok(input mode_t m, input logic [7:0] pfc,
			input logic [11:0] ts, input logic [11:0] col, input logic is_real,
			input kbuf_t kb, input logic [15:0] line, input logic [12:0] kw_chars);
		flush_t f;
		logic [6:0] sk;
		f.v = 1'b0;
		f.t = '0;
		sk = starter_kind(pfc);
		case (m)
			MODE_OP: begin
				f.v = 1'b1;
				f.t = mk_tok(sk[6] ? sk[5:0] : KIND_DOT, line, ts, 12'd1);
			end
			MODE_NUMBER: begin
				f.v = 1'b1;
				f.t = mk_tok(is_real ? KIND_REAL : KIND_INT, line, ts, span(col, ts));
			end
			MODE_STRING: begin
				f.v = 1'b1;
				f.t = mk_tok(KIND_STRING, line, ts, span(col, ts));
			end
			MODE_WORD: begin
				f.v = 1'b1;
				f.t = mk_tok(classify(kb, span(col, ts), kw_chars), line, ts, span(col, ts));
			end
			default: f.v = 1'b0;
		endcase
		return f;
	endfunction

endpackage

/* src/sts_core.sv */
// Scanner core: input register, scan state and the one-byte step logic.
// Depends on sts_pkg; feeds up to two results per byte to sts_out_fifo.
module sts_core #(
	parameter int LINE_LENGTH_MAX = sts_pkg::LINE_LENGTH_MAX_DEF,
	parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      text_byte,
	input  logic            stream_end,
	input  logic            room,
	output logic            res_valid,
	output sts_pkg::rlist_t res_list
);
	import sts_pkg::*;

	localparam int COL_CAP_I = (LINE_LENGTH_MAX - 1 < 4095) ? LINE_LENGTH_MAX - 1 : 4095;
	localparam logic [11:0] COL_CAP = 12'(COL_CAP_I);
	localparam logic [12:0] KW_CHARS = 13'(KEYWORD_CHARS);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        proc;

	mode_t       mode_q, mode_d;
	logic [7:0]  pfc_q, pfc_d;
	logic [15:0] line_q, line_d;
	logic [11:0] col_q, col_d;
	logic [11:0] ts_q, ts_d;
	logic        real_q, real_d;
	kbuf_t       kb_q, kb_d;
	rlist_t      lst;

	assign proc = v_s1 && room;
	assign in_ready = !v_s1 || room;
	assign res_valid = proc;
	assign res_list = lst;

	// Hold the accepted byte until the result queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			end_s1 <= stream_end;
		end
	end

	// One byte step
	always_comb begin
		logic [15:0] ln_out;
		logic [11:0] col;
		logic [11:0] idx;
		logic        used;
		logic [6:0]  pk;
		logic [6:0]  lk;
		logic [6:0]  sk;
		flush_t      f;
		mode_d = mode_q;
		pfc_d = pfc_q;
		line_d = line_q;
		col_d = col_q;
		ts_d = ts_q;
		real_d = real_q;
		kb_d = kb_q;
		lst = '0;
		used = 1'b0;
		col = col_q;
		idx = 12'd0;
		ln_out = (line_q == 16'hFFFF) ? 16'hFFFF : line_q + 16'd1;
		pk = pair_kind(pfc_q, byte_s1);
		lk = lone_kind(byte_s1);
		sk = starter_kind(byte_s1);
		f = flush_tok(mode_q, pfc_q, ts_q, col_q, real_q, kb_q, ln_out, KW_CHARS);
		if (byte_s1 == CH_NEWLINE) begin
			if (f.v) lst = put(lst, f.t);
			mode_d = MODE_IDLE;
			line_d = ln_out;
			col_d = 12'd0;
		end else begin
			case (mode_q)
				MODE_OP: begin
					if (pk[6]) begin
						lst = put(lst, mk_tok(pk[5:0], ln_out, ts_q, 12'd2));
						mode_d = MODE_IDLE;
						used = 1'b1;
					end else if (pfc_q == CH_DOT && is_digit(byte_s1)) begin
						mode_d = MODE_NUMBER;
						real_d = 1'b1;
						used = 1'b1;
					end else begin
						if (f.v) lst = put(lst, f.t);
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(byte_s1)) begin
						used = 1'b1;
					end else if (byte_s1 == CH_DOT && !real_q) begin
						real_d = 1'b1;
						used = 1'b1;
					end else begin
						if (f.v) lst = put(lst, f.t);
						mode_d = MODE_IDLE;
					end
				end
				MODE_STRING: begin
					if (byte_s1 == CH_QUOTE) begin
						lst = put(lst, mk_tok(KIND_STRING, ln_out, ts_q, span(col, ts_q)));
						mode_d = MODE_IDLE;
					end
					used = 1'b1;
				end
				MODE_WORD: begin
					if (is_word_char(byte_s1)) begin
						idx = span(col, ts_q);
						if (idx < 12'(KW_MAX_LEN)) kb_d[idx[2:0]] = byte_s1;
						used = 1'b1;
					end else begin
						if (f.v) lst = put(lst, f.t);
						mode_d = MODE_IDLE;
					end
				end
				MODE_COMMENT: used = 1'b1;
				default: mode_d = MODE_IDLE;
			endcase
			// Start a new token on this byte
			if (!used) begin
				if (lk[6]) begin
					lst = put(lst, mk_tok(lk[5:0], ln_out, col, 12'd1));
				end else if (sk[6]) begin
					mode_d = MODE_OP;
					pfc_d = byte_s1;
					ts_d = col;
				end else if (byte_s1 == CH_HASH) begin
					mode_d = MODE_COMMENT;
				end else if (byte_s1 == CH_QUOTE) begin
					mode_d = MODE_STRING;
					ts_d = (col < COL_CAP) ? col + 12'd1 : COL_CAP;
				end else if (is_blank(byte_s1)) begin
					used = 1'b0;
				end else if (is_digit(byte_s1)) begin
					mode_d = MODE_NUMBER;
					real_d = 1'b0;
					ts_d = col;
				end else begin
					mode_d = MODE_WORD;
					ts_d = col;
					kb_d[0] = byte_s1;
				end
			end
			col_d = (col < COL_CAP) ? col + 12'd1 : COL_CAP;
		end
		// Flush at the end of the stream and restart position
		if (end_s1) begin
			f = flush_tok(mode_d, pfc_d, ts_d, col_d, real_d, kb_d, ln_out, KW_CHARS);
			if (f.v) lst = put(lst, f.t);
			mode_d = MODE_IDLE;
			line_d = 16'd0;
			col_d = 12'd0;
		end
		if (lst.n == 2'd1) lst.r0.last = 1'b1;
		if (lst.n == 2'd2) lst.r1.last = 1'b1;
	end

	// Advance scan state when the byte is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pfc_q <= 8'd0;
			line_q <= 16'd0;
			col_q <= 12'd0;
			ts_q <= 12'd0;
			real_q <= 1'b0;
		end else if (proc) begin
			mode_q <= mode_d;
			pfc_q <= pfc_d;
			line_q <= line_d;
			col_q <= col_d;
			ts_q <= ts_d;
			real_q <= real_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) kb_q <= kb_d;
	end

endmodule

/* src/sts_out_fifo.sv */
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on sts_pkg for the result types.
module sts_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sts_pkg::rlist_t push_list,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output sts_pkg::tok_t   head,
	output logic [2:0]      count
);
	import sts_pkg::*;

	tok_t       mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic [1:0] n_in;
	logic       pop;

	assign n_in = push ? push_list.n : 2'd0;
	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign head = mem_q[rd_q];
	assign room = (cnt_q <= 3'd2);
	assign count = cnt_q;

	// Write up to two results
	always_ff @(posedge clk) begin
		if (n_in != 2'd0) mem_q[wr_q] <= push_list.r0;
		if (n_in == 2'd2) mem_q[wr_q + 2'd1] <= push_list.r1;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q <= wr_q + n_in;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, n_in} - {2'b00, pop};
		end
	end

endmodule

/* src/script_token_scanner.sv */
// Top level of the token scanner: core step logic plus result queue.
// Depends on sts_pkg, sts_core and sts_out_fifo.
//
// Takes one source byte per cycle while the result queue has room, and reports each
// finished token with its kind, line, start column and length. A byte goes into an
// input register and is scanned from there once the result queue has room; its
// results are written into the queue when it is scanned and are offered at the
// output from the queue. A new byte can be accepted while the held byte is scanned.
// A byte may finish up to two tokens; both go into a four-entry result queue and
// are delivered one per cycle while the output takes them, and the byte register
// waits while fewer than two queue entries are free. The last result a byte causes
// carries last_result.
module script_token_scanner #(
	parameter int LINE_LENGTH_MAX = sts_pkg::LINE_LENGTH_MAX_DEF,
	parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [15:0] token_line,
	output logic [11:0] start_column,
	output logic [12:0] token_length,
	output logic        last_result
);
	import sts_pkg::*;

	logic       room;
	logic       res_valid;
	rlist_t     res_list;
	tok_t       head;
	logic [2:0] count;

	sts_core #(
		.LINE_LENGTH_MAX(LINE_LENGTH_MAX),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.stream_end(stream_end),
		.room(room),
		.res_valid(res_valid),
		.res_list(res_list)
	);

	sts_out_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_list(res_list),
		.room(room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head),
		.count(count)
	);

	assign token_kind = head.kind;
	assign token_line = head.line;
	assign start_column = head.start;
	assign token_length = head.len;
	assign last_result = head.last;

	// Queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= 3'd4) else $error("result queue overflow");

	// A push only happens with two free entries
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> count <= 3'd2) else $error("push without room");

	// Count holds when nothing is pushed or popped
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !(out_valid && out_ready) |=> $stable(count))
		else $error("queue count changed without traffic");

endmodule
